/* sv/lcdseq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, codes and next-state helpers for the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  localparam int WAIT_WIDTH = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_WAIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LONG_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SHORT_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_WAIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS     = 3'd5;

  // register reset values
  localparam logic [CFG_W-1:0] RST_POWER_ON_WAIT   = 16'd20000;
  localparam logic [CFG_W-1:0] RST_INIT_LONG_WAIT  = 16'd5000;
  localparam logic [CFG_W-1:0] RST_INIT_SHORT_WAIT = 16'd100;
  localparam logic [CFG_W-1:0] RST_COMMAND_WAIT    = 16'd40;
  localparam logic [CFG_W-1:0] RST_CLEAR_WAIT      = 16'd2000;
  localparam logic [7:0]       RST_PULSE_TICKS     = 8'd1;

  // sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_PULSE = 3'd2;
  localparam logic [2:0] PH_HOLD  = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;

  // init bookkeeping
  localparam logic [3:0] STEP_NONE       = 4'd0;
  localparam logic [3:0] STEP_FIRST      = 4'd1;
  localparam logic [3:0] STEP_AFTER_ONE  = 4'd2;
  localparam logic [3:0] STEP_AFTER_TWO  = 4'd3;
  localparam logic [3:0] STEP_LAST_NIB   = 4'd4;
  localparam logic [3:0] STEP_AFTER_NIB  = 4'd5;
  localparam logic [3:0] STEP_LAST_ITEM  = 4'd9;
  localparam logic [3:0] STEP_BYTE_BASE  = 4'd5;

  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] NIB_THREE = 8'h03;
  localparam logic [7:0] NIB_TWO   = 8'h02;

  typedef struct packed {
    logic [1:0] req_type;
    logic       rs;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    logic       lcd_rs;
    logic       lcd_en;
    logic [3:0] lcd_nibble;
    logic       busy_res;
    logic       accepted;
  } res_t;

  typedef struct packed {
    logic [WAIT_WIDTH-1:0] power_on_wait;
    logic [WAIT_WIDTH-1:0] init_long_wait;
    logic [WAIT_WIDTH-1:0] init_short_wait;
    logic [WAIT_WIDTH-1:0] command_wait;
    logic [WAIT_WIDTH-1:0] clear_wait;
    logic [7:0]            pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]            phase;
    logic [WAIT_WIDTH-1:0] wait_count;
    logic [3:0]            init_step;
    logic [7:0]            pending_byte;
    logic                  pending_select;
    logic                  low_nibble_next;
    logic                  pin_select;
    logic [3:0]            pin_nibble;
  } seq_state_t;

  // zero-extend or cut a config word to the wait counter width
  function automatic logic [WAIT_WIDTH-1:0] fit_wait(logic [CFG_W-1:0] v);
    logic [CFG_W+WAIT_WIDTH-1:0] t;
    t = {{WAIT_WIDTH{1'b0}}, v};
    return t[WAIT_WIDTH-1:0];
  endfunction

  function automatic logic [7:0] init_byte(logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h01;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h0C;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  function automatic seq_state_t start_nibble(seq_state_t s);
    seq_state_t r;
    r = s;
    r.pin_nibble = s.low_nibble_next ? s.pending_byte[3:0] : s.pending_byte[7:4];
    r.pin_select = s.pending_select;
    r.phase      = PH_SETUP;
    r.wait_count = {{(WAIT_WIDTH-1){1'b0}}, 1'b1};
    return r;
  endfunction

  function automatic seq_state_t start_item(seq_state_t s);
    seq_state_t r;
    logic [3:0] d;
    r = s;
    d = s.init_step - STEP_BYTE_BASE;
    if (s.init_step <= STEP_LAST_NIB) begin
      r.pending_byte    = (s.init_step == STEP_LAST_NIB) ? NIB_TWO : NIB_THREE;
      r.low_nibble_next = 1'b1;
    end else begin
      r.pending_byte    = init_byte(d[2:0]);
      r.low_nibble_next = 1'b0;
    end
    r.pending_select = 1'b0;
    r.init_step      = s.init_step + 4'd1;
    return start_nibble(r);
  endfunction

  function automatic seq_state_t after_wait(seq_state_t s);
    seq_state_t r;
    r = s;
    if (s.init_step >= STEP_FIRST && s.init_step <= STEP_LAST_ITEM) begin
      r = start_item(s);
    end else begin
      r.phase      = PH_IDLE;
      r.init_step  = STEP_NONE;
      r.wait_count = '0;
    end
    return r;
  endfunction

  function automatic seq_state_t enter_wait(seq_state_t s, logic [WAIT_WIDTH-1:0] w);
    seq_state_t r;
    r = s;
    if (w == '0) begin
      r = after_wait(s);
    end else begin
      r.phase      = PH_WAIT;
      r.wait_count = w;
    end
    return r;
  endfunction

  function automatic logic [WAIT_WIDTH-1:0] wait_after(seq_state_t s, cfg_t c);
    logic [WAIT_WIDTH-1:0] w;
    if (s.init_step == STEP_AFTER_ONE) begin
      w = c.init_long_wait;
    end else if (s.init_step == STEP_AFTER_TWO) begin
      w = c.init_short_wait;
    end else if (s.init_step == STEP_LAST_NIB || s.init_step == STEP_AFTER_NIB) begin
      w = c.command_wait;
    end else if (!s.pending_select && s.pending_byte == CMD_CLEAR) begin
      w = c.clear_wait;
    end else begin
      w = c.command_wait;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

/* sv/char_lcd_4bit_write_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer
// Four-bit character LCD write sequencer, one microsecond tick per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i): one word per tick.
//   A tick word, a byte write or an init request; requests while busy are
//   refused and the word still counts as one tick.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one word
//   per input word, holding the LCD pin levels for that tick, busy and
//   whether the request was taken.
//   Latency: the result word is shown the cycle after its input word, unless
//   it goes to the skid slot. Throughput: one word per clock while in_stall_o
//   is low; the step is a single pass of logic between the state register
//   and the two-entry result buffer. A receiver stall fills the buffer;
//   after two words in_stall_o rises and stays high until a word is taken.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once and are to be made while the block is idle.
//   Reset: sequencer idle, pins low, buffer empty, registers at defaults.
// ----------------------------------------------------------------------------
module char_lcd_4bit_write_sequencer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire lcdseq_pkg::req_t                    in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output lcdseq_pkg::res_t                         out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [lcdseq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [lcdseq_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import lcdseq_pkg::*;

  cfg_t cfg_q;
  res_t step_res;
  logic step;
  logic buf_full;

  assign step       = in_valid_i && !buf_full;
  assign in_stall_o = buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_on_wait   <= fit_wait(RST_POWER_ON_WAIT);
      cfg_q.init_long_wait  <= fit_wait(RST_INIT_LONG_WAIT);
      cfg_q.init_short_wait <= fit_wait(RST_INIT_SHORT_WAIT);
      cfg_q.command_wait    <= fit_wait(RST_COMMAND_WAIT);
      cfg_q.clear_wait      <= fit_wait(RST_CLEAR_WAIT);
      cfg_q.pulse_ticks     <= RST_PULSE_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POWER_ON_WAIT:   cfg_q.power_on_wait   <= fit_wait(cfg_wdata_i);
        CFG_INIT_LONG_WAIT:  cfg_q.init_long_wait  <= fit_wait(cfg_wdata_i);
        CFG_INIT_SHORT_WAIT: cfg_q.init_short_wait <= fit_wait(cfg_wdata_i);
        CFG_COMMAND_WAIT:    cfg_q.command_wait    <= fit_wait(cfg_wdata_i);
        CFG_CLEAR_WAIT:      cfg_q.clear_wait      <= fit_wait(cfg_wdata_i);
        CFG_PULSE_TICKS:     cfg_q.pulse_ticks     <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  lcdseq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  lcdseq_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_data_i (step_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* sv/lcdseq_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_core
// Sequencer state and the single-tick step: request intake, pin levels, advance.
// ----------------------------------------------------------------------------
module lcdseq_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire lcdseq_pkg::req_t  req_i,
  input  wire lcdseq_pkg::cfg_t  cfg_i,
  output lcdseq_pkg::res_t       res_o
);
  import lcdseq_pkg::*;

  seq_state_t state_q, state_d;

  always_comb begin
    seq_state_t s;
    logic       acc;
    logic       busy;
    s    = state_q;
    acc  = 1'b0;

    if (s.phase == PH_IDLE) begin
      if (req_i.req_type == REQ_WRITE) begin
        s.pending_byte    = req_i.data;
        s.pending_select  = req_i.rs;
        s.low_nibble_next = 1'b0;
        s.init_step       = STEP_NONE;
        s = start_nibble(s);
        acc = 1'b1;
      end else if (req_i.req_type == REQ_INIT) begin
        s.pin_select = 1'b0;
        s.init_step  = STEP_FIRST;
        s = enter_wait(s, cfg_i.power_on_wait);
        acc = 1'b1;
      end
    end

    busy = (s.phase != PH_IDLE);
    res_o.lcd_rs     = s.pin_select;
    res_o.lcd_en     = busy && (s.phase == PH_PULSE);
    res_o.lcd_nibble = s.pin_nibble;
    res_o.busy_res   = busy;
    res_o.accepted   = acc;

    case (s.phase)
      PH_IDLE: begin
      end
      PH_SETUP: begin
        s.phase      = PH_PULSE;
        s.wait_count = (cfg_i.pulse_ticks == 8'd0) ? {{(WAIT_WIDTH-1){1'b0}}, 1'b1}
                                                   : {{(WAIT_WIDTH-8){1'b0}}, cfg_i.pulse_ticks};
      end
      PH_PULSE: begin
        s.wait_count = s.wait_count - {{(WAIT_WIDTH-1){1'b0}}, 1'b1};
        if (s.wait_count == '0) s.phase = PH_HOLD;
      end
      PH_HOLD: begin
        if (!s.low_nibble_next) begin
          s.low_nibble_next = 1'b1;
          s = start_nibble(s);
        end else begin
          s = enter_wait(s, wait_after(s, cfg_i));
        end
      end
      PH_WAIT: begin
        s.wait_count = s.wait_count - {{(WAIT_WIDTH-1){1'b0}}, 1'b1};
        if (s.wait_count == '0) s = after_wait(s);
      end
      default: s.phase = PH_IDLE;
    endcase

    state_d = step_i ? s : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

/* sv/lcdseq_outbuf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_outbuf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module lcdseq_outbuf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lcdseq_pkg::res_t  push_data_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lcdseq_pkg::res_t       out_data_o
);
  import lcdseq_pkg::*;

  res_t       head_q, head_d;
  res_t       skid_q, skid_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = head_q;

  always_comb begin
    head_d  = head_q;
    skid_d  = skid_q;
    count_d = count_q;
    case ({push_i, pop})
      2'b10: begin
        if (count_q == 2'd0) head_d = push_data_i;
        else                 skid_d = push_data_i;
        count_d = count_q + 2'd1;
      end
      2'b01: begin
        head_d  = skid_q;
        count_d = count_q - 2'd1;
      end
      2'b11: begin
        // count is one here: the new word goes straight to the head
        head_d = push_data_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule
`default_nettype wire

/* dv/lcdseq_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdseq_tb_pkg
// Pin-level predictor and scoreboard for the 4-bit LCD write sequencer.
// Every accepted input word is one tick; the predictor steps its own copy of
// the sequencer and queues the pin levels, busy and accept flags for it.
// ----------------------------------------------------------------------------
package lcdseq_tb_pkg;

  import lcdseq_pkg::*;

  class lcd_pin_scoreboard;

    // register copy
    logic [15:0] power_on_wait;
    logic [15:0] init_long_wait;
    logic [15:0] init_short_wait;
    logic [15:0] command_wait;
    logic [15:0] clear_wait;
    logic [7:0]  pulse_ticks;

    // sequencer copy
    logic [2:0]  phase;
    logic [15:0] count;
    logic [3:0]  init_idx;
    logic [7:0]  byte_q;
    logic        sel_q;
    logic        low_next;
    logic        pin_rs;
    logic [3:0]  pin_nib;

    res_t        pin_levels_q[$];
    int unsigned errors;

    function new();
      power_on_wait   = RST_POWER_ON_WAIT;
      init_long_wait  = RST_INIT_LONG_WAIT;
      init_short_wait = RST_INIT_SHORT_WAIT;
      command_wait    = RST_COMMAND_WAIT;
      clear_wait      = RST_CLEAR_WAIT;
      pulse_ticks     = RST_PULSE_TICKS;
      phase    = PH_IDLE;
      count    = '0;
      init_idx = STEP_NONE;
      byte_q   = '0;
      sel_q    = 1'b0;
      low_next = 1'b0;
      pin_rs   = 1'b0;
      pin_nib  = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_POWER_ON_WAIT:   power_on_wait   = v;
        CFG_INIT_LONG_WAIT:  init_long_wait  = v;
        CFG_INIT_SHORT_WAIT: init_short_wait = v;
        CFG_COMMAND_WAIT:    command_wait    = v;
        CFG_CLEAR_WAIT:      clear_wait      = v;
        CFG_PULSE_TICKS:     pulse_ticks     = v[7:0];
        default: ;
      endcase
    endfunction

    function bit seq_idle();
      return phase == PH_IDLE;
    endfunction

    function int unsigned pending();
      return pin_levels_q.size();
    endfunction

    function void load_nibble();
      pin_nib = low_next ? byte_q[3:0] : byte_q[7:4];
      pin_rs  = sel_q;
      phase   = PH_SETUP;
      count   = 16'd1;
    endfunction

    // power-on command bytes after the four single nibbles
    function logic [7:0] init_cmd(logic [3:0] k);
      logic [7:0] b;
      case (k)
        4'd0:    b = 8'h28;
        4'd1:    b = 8'h08;
        4'd2:    b = CMD_CLEAR;
        4'd3:    b = 8'h06;
        default: b = 8'h0C;
      endcase
      return b;
    endfunction

    function void next_init_item();
      if (init_idx <= STEP_LAST_NIB) begin
        byte_q   = (init_idx == STEP_LAST_NIB) ? NIB_TWO : NIB_THREE;
        low_next = 1'b1;
      end else begin
        byte_q   = init_cmd(init_idx - STEP_BYTE_BASE);
        low_next = 1'b0;
      end
      sel_q    = 1'b0;
      init_idx = init_idx + 4'd1;
      load_nibble();
    endfunction

    function void wait_done();
      if (init_idx >= STEP_FIRST && init_idx <= STEP_LAST_ITEM) begin
        next_init_item();
      end else begin
        phase    = PH_IDLE;
        init_idx = STEP_NONE;
        count    = '0;
      end
    endfunction

    // zero wait falls straight through to whatever follows
    function void begin_wait(logic [15:0] w);
      if (w == '0) begin
        wait_done();
      end else begin
        phase = PH_WAIT;
        count = w;
      end
    endfunction

    function logic [15:0] gap_after_byte();
      if (init_idx == STEP_AFTER_ONE) return init_long_wait;
      if (init_idx == STEP_AFTER_TWO) return init_short_wait;
      if (init_idx == STEP_LAST_NIB || init_idx == STEP_AFTER_NIB) return command_wait;
      if (!sel_q && byte_q == CMD_CLEAR) return clear_wait;
      return command_wait;
    endfunction

    function void advance();
      case (phase)
        PH_SETUP: begin
          phase = PH_PULSE;
          count = (pulse_ticks == '0) ? 16'd1 : {8'd0, pulse_ticks};
        end
        PH_PULSE: begin
          count = count - 16'd1;
          if (count == '0) phase = PH_HOLD;
        end
        PH_HOLD: begin
          if (!low_next) begin
            low_next = 1'b1;
            load_nibble();
          end else begin
            begin_wait(gap_after_byte());
          end
        end
        PH_WAIT: begin
          count = count - 16'd1;
          if (count == '0) wait_done();
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    // one accepted word = one tick
    function void step_pins(req_t w);
      res_t r;
      r = '0;
      if (phase == PH_IDLE) begin
        if (w.req_type == REQ_WRITE) begin
          byte_q   = w.data;
          sel_q    = w.rs;
          low_next = 1'b0;
          init_idx = STEP_NONE;
          load_nibble();
          r.accepted = 1'b1;
        end else if (w.req_type == REQ_INIT) begin
          pin_rs   = 1'b0;
          init_idx = STEP_FIRST;
          begin_wait(power_on_wait);
          r.accepted = 1'b1;
        end
      end
      r.busy_res   = (phase != PH_IDLE);
      r.lcd_en     = (phase == PH_PULSE);
      r.lcd_rs     = pin_rs;
      r.lcd_nibble = pin_nib;
      pin_levels_q.push_back(r);
      if (phase != PH_IDLE) advance();
    endfunction

    function void compare_field(string field, logic [3:0] want, logic [3:0] got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_pins(res_t got);
      res_t want;
      if (pin_levels_q.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        errors++;
      end else begin
        want = pin_levels_q.pop_front();
        compare_field("lcd_rs", 4'(want.lcd_rs), 4'(got.lcd_rs));
        compare_field("lcd_en", 4'(want.lcd_en), 4'(got.lcd_en));
        compare_field("lcd_nibble", want.lcd_nibble, got.lcd_nibble);
        compare_field("busy_res", 4'(want.busy_res), 4'(got.busy_res));
        compare_field("accepted", 4'(want.accepted), 4'(got.accepted));
      end
    endfunction

    function void flag_leftovers();
      if (pin_levels_q.size() != 0) begin
        $error("%0d result words never arrived", pin_levels_q.size());
        errors++;
      end
    endfunction

  endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the LCD write sequencer with tick, write and init words under
// bursty input and a stalling receiver, and checks every result word
// against the scoreboard's prediction across several register settings.
// ----------------------------------------------------------------------------
module testbench;

  import lcdseq_pkg::*;
  import lcdseq_tb_pkg::*;

  localparam logic [1:0]  REQ_SPARE    = 2'd3;
  localparam int          RANDOM_WORDS = 280;
  localparam int          SETTLE_TICKS = 6;
  localparam int          HOLDOFF_LEN  = 300;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  req_t                 in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  res_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  lcd_pin_scoreboard sb = new();

  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned cycle_count;
  bit          rx_holdoff_req;
  int unsigned rx_holdoff_left;
  int unsigned rx_mode;
  int unsigned rx_mode_left;

  char_lcd_4bit_write_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) sb.check_pins(out_data);
    if (rx_holdoff_req) begin
      rx_holdoff_req  = 1'b0;
      rx_holdoff_left = HOLDOFF_LEN;
    end
    if (rx_holdoff_left != 0) begin
      rx_holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(8, 80);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic req_t make_word(logic [1:0] kind, logic sel, logic [7:0] b);
    req_t w;
    w.req_type = kind;
    w.rs       = sel;
    w.data     = b;
    return w;
  endfunction

  function automatic req_t any_tick();
    return make_word(($urandom_range(0, 3) == 0) ? REQ_SPARE : REQ_TICK,
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endfunction

  // offer one word; bursts of random length, usually with a gap between them
  task automatic send_word(input req_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
    sb.step_pins(w);
    words_sent++;
  endtask

  task automatic run_until_idle();
    while (!sb.seq_idle()) send_word(any_tick());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  // upper byte of the pulse word is junk the block must drop
  task automatic load_settings(input cfg_t c);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    reg_write(CFG_POWER_ON_WAIT, c.power_on_wait);
    reg_write(CFG_INIT_LONG_WAIT, c.init_long_wait);
    reg_write(CFG_INIT_SHORT_WAIT, c.init_short_wait);
    reg_write(CFG_COMMAND_WAIT, c.command_wait);
    reg_write(CFG_CLEAR_WAIT, c.clear_wait);
    reg_write(CFG_PULSE_TICKS, {junk, c.pulse_ticks});
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed requests run to completion, with refused and spare
  // words sprinkled into the busy stretch
  task automatic run_random(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    req_t        w;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        w = make_word(REQ_WRITE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0) w = make_word(REQ_WRITE, 1'b0, CMD_CLEAR);
      end else if (pick < 16) begin
        w = make_word(REQ_INIT, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        w = any_tick();
      end
      send_word(w);
      while (!sb.seq_idle()) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(make_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255))));
        end else begin
          send_word(any_tick());
        end
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings; requests while busy are refused
    send_word(make_word(REQ_TICK, 1'b1, 8'hFF));
    send_word(make_word(REQ_SPARE, 1'b0, 8'h00));
    send_word(make_word(REQ_WRITE, 1'b1, 8'h5A));
    send_word(make_word(REQ_TICK, 1'b0, 8'h00));
    send_word(make_word(REQ_INIT, 1'b1, 8'hFF));
    send_word(make_word(REQ_WRITE, 1'b0, CMD_CLEAR));
    run_until_idle();
    send_word(make_word(REQ_WRITE, 1'b1, CMD_CLEAR));
    run_until_idle();
    send_word(make_word(REQ_WRITE, 1'b0, 8'h00));
    run_until_idle();

    // longer command wait and pulse
    settle();
    c = '{power_on_wait: 16'd0, init_long_wait: 16'd0, init_short_wait: 16'd0,
          command_wait: 16'd60, clear_wait: 16'd80, pulse_ticks: 8'd12};
    load_settings(c);
    send_word(make_word(REQ_WRITE, 1'b1, 8'hA5));
    run_until_idle();
    send_word(make_word(REQ_WRITE, 1'b0, CMD_CLEAR));
    run_until_idle();

    // every wait zero, pulse written as zero
    settle();
    c = '{power_on_wait: 16'd0, init_long_wait: 16'd0, init_short_wait: 16'd0,
          command_wait: 16'd0, clear_wait: 16'd0, pulse_ticks: 8'd0};
    load_settings(c);
    send_word(make_word(REQ_INIT, 1'b1, 8'h00));
    run_until_idle();
    send_word(make_word(REQ_WRITE, 1'b0, CMD_CLEAR));
    run_until_idle();
    send_word(make_word(REQ_WRITE, 1'b1, 8'h3C));
    run_until_idle();
    send_word(make_word(REQ_WRITE, 1'b1, 8'hC3));
    run_until_idle();

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      c.power_on_wait   = 16'($urandom_range(0, 8));
      c.init_long_wait  = 16'($urandom_range(0, 8));
      c.init_short_wait = 16'($urandom_range(0, 6));
      c.command_wait    = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      c.clear_wait      = 16'($urandom_range(0, 10));
      c.pulse_ticks     = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 3));
      load_settings(c);
      // receiver holds off while the sender keeps offering
      if (ph == 0) rx_holdoff_req = 1'b1;
      run_random(RANDOM_WORDS / 4);
    end

    settle();
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lcdseq_pkg.sv
sv/lcdseq_core.sv
sv/lcdseq_outbuf.sv
sv/char_lcd_4bit_write_sequencer.sv
dv/lcdseq_tb_pkg.sv
dv/testbench.sv
